// ===== sv/scdb_pkg.sv =====
package scdb_pkg;

    localparam int unsigned FRAME_BITS = 27;

    localparam logic [2:0] ADDR_DEVICE_ADDRESS = 3'h0;
    localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'h60;

    localparam logic [7:0] SHUTDOWN_UPPER = 8'h30;
    localparam logic [7:0] SHUTDOWN_LOWER = 8'h00;

    localparam logic [5:0] SLOT_IDLE      = 6'd0;
    localparam logic [5:0] SLOT_START     = 6'd1;
    localparam logic [5:0] SLOT_BITS_LAST = 6'd55;
    localparam logic [5:0] SLOT_PRE_LOW   = 6'd56;
    localparam logic [5:0] SLOT_PRE_HIGH  = 6'd57;
    localparam logic [5:0] SLOT_STOP      = 6'd58;

    typedef struct packed {
        logic [7:0] upper;
        logic [7:0] lower;
    } cmd_t;

endpackage

// ===== sv/scdb_front.sv =====
module scdb_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    input  logic [7:0]       rx_byte,
    output logic             cmd_push,
    output scdb_pkg::cmd_t   cmd
);
    import scdb_pkg::*;

    logic       first_held_reg;
    logic       first_held_next;
    logic [6:0] held_high_reg;
    logic [6:0] held_high_next;
    logic [11:0] word;

    always_comb
    begin
        first_held_next = first_held_reg;
        held_high_next  = held_high_reg;
        cmd_push        = 1'b0;
        word            = {held_high_reg, rx_byte[5:1]};
        if (rx_byte[6])
        begin
            cmd.upper = SHUTDOWN_UPPER;
            cmd.lower = SHUTDOWN_LOWER;
        end
        else
        begin
            cmd.upper = {4'b0000, word[11:8]};
            cmd.lower = word[7:0];
        end
        if (byte_valid)
        begin
            if (rx_byte[0])
            begin
                first_held_next = 1'b1;
                held_high_next  = rx_byte[7:1];
            end
            else if (first_held_reg)
            begin
                first_held_next = 1'b0;
                cmd_push        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_held_reg <= 1'b0;
            held_high_reg  <= 7'd0;
        end
        else
        begin
            first_held_reg <= first_held_next;
            held_high_reg  <= held_high_next;
        end
    end

endmodule

// ===== sv/scdb_fifo.sv =====
module scdb_fifo
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  scdb_pkg::cmd_t   push_cmd,
    input  logic             pop,
    output scdb_pkg::cmd_t   pop_cmd,
    output logic             full,
    output logic             empty
);
    import scdb_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/scdb_back.sv =====
module scdb_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [6:0]       device_address,
    input  logic             cmd_avail,
    input  scdb_pkg::cmd_t   cmd,
    output logic             cmd_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import scdb_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic [5:0]            slot_reg;
    logic [5:0]            slot_next;
    logic [FRAME_BITS-1:0] bits_reg;
    logic [FRAME_BITS-1:0] bits_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  scl_reg;
    logic                  scl_next;
    logic                  sda_reg;
    logic                  sda_next;
    logic                  last_reg;
    logic                  last_next;
    logic                  advance;

    assign advance = busy_reg && (!out_valid_reg || m_tready);
    assign cmd_pop = !busy_reg && cmd_avail;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, sda_reg, scl_reg};
    assign m_tlast  = last_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        slot_next      = slot_reg;
        bits_next      = bits_reg;
        out_valid_next = out_valid_reg && !m_tready;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        last_next      = last_reg;
        if (cmd_pop)
        begin
            busy_next = 1'b1;
            slot_next = SLOT_IDLE;
            bits_next = {device_address, 1'b0, 1'b1, cmd.upper, 1'b1, cmd.lower, 1'b1};
        end
        else if (advance)
        begin
            out_valid_next = 1'b1;
            last_next      = 1'b0;
            slot_next      = slot_reg + 1'b1;
            if (slot_reg == SLOT_IDLE)
            begin
                scl_next = 1'b1;
                sda_next = 1'b1;
            end
            else if (slot_reg == SLOT_START)
            begin
                scl_next = 1'b1;
                sda_next = 1'b0;
            end
            else if (slot_reg <= SLOT_BITS_LAST)
            begin
                scl_next = slot_reg[0];
                sda_next = bits_reg[FRAME_BITS-1];
                if (slot_reg[0])
                begin
                    bits_next = {bits_reg[FRAME_BITS-2:0], 1'b0};
                end
            end
            else if (slot_reg == SLOT_PRE_LOW)
            begin
                scl_next = 1'b0;
                sda_next = 1'b0;
            end
            else if (slot_reg == SLOT_PRE_HIGH)
            begin
                scl_next = 1'b1;
                sda_next = 1'b0;
            end
            else
            begin
                scl_next  = 1'b1;
                sda_next  = 1'b1;
                last_next = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        bits_reg <= bits_next;
        scl_reg  <= scl_next;
        sda_reg  <= sda_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/serial_command_to_i2c_dac_bridge.sv =====
// serial command to i2c dac bridge
// s_t* takes received command bytes, one byte per word, at up to one per cycle
// while the command queue has room. a byte with bit 0 set is held as the first
// byte of a command; a following byte with bit 0 clear completes it and queues
// one i2c write frame (shutdown bytes when its bit 6 is set)
// m_t* gives the frame as 59 line slots, one slot per word: tdata bit 0 is scl,
// bit 1 is sda, tlast marks the stop slot. frames go out one after another from
// the queue, one slot per cycle while the receiver takes them; the next command
// is loaded from the queue after the stop slot of the frame before is registered
// the first slot is registered after the command passes the queue and is popped
// a stall on m_t* holds the current slot; the queue of QUEUE_DEPTH commands
// keeps taking bytes until it fills, then s_tready drops
// the apb port holds device_address at byte address 0, read and write
// reset clears the held byte, empties the queue, drops m_tvalid and sets
// device_address to 0x60
module serial_command_to_i2c_dac_bridge
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // scl_level, sda_level, zero fill
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scdb_pkg::*;

    logic       dev_addr_sel;
    logic [6:0] device_address_reg;
    logic [6:0] device_address_next;
    logic       cfg_write;
    logic       byte_accept;
    logic       cmd_push;
    cmd_t       front_cmd;
    cmd_t       queue_cmd;
    logic       queue_full;
    logic       queue_empty;
    logic       cmd_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign dev_addr_sel = (paddr == ADDR_DEVICE_ADDRESS);
    assign prdata    = dev_addr_sel ? {25'd0, device_address_reg} : 32'd0;

    always_comb
    begin
        device_address_next = device_address_reg;
        if (cfg_write && dev_addr_sel)
        begin
            device_address_next = pwdata[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= DEVICE_ADDRESS_RESET;
        end
        else
        begin
            device_address_reg <= device_address_next;
        end
    end

    assign s_tready    = !queue_full;
    assign byte_accept = s_tvalid && s_tready;

    scdb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_accept),
        .rx_byte    (s_tdata),
        .cmd_push   (cmd_push),
        .cmd        (front_cmd)
    );

    scdb_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (front_cmd),
        .pop      (cmd_pop),
        .pop_cmd  (queue_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    scdb_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .device_address (device_address_reg),
        .cmd_avail      (!queue_empty),
        .cmd            (queue_cmd),
        .cmd_pop        (cmd_pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast)
    );

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !queue_full)
    else $error("command pushed into a full queue");

    a_stop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[0] && m_tdata[1]))
    else $error("frame end slot is not a stop condition");

    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("gap inside a frame");

endmodule
